[hdl/cfsp_pkg.sv]
// ----------------------------------------------------------------------------
// cfsp_pkg
// shared types and constants of the class file stream parser
// ----------------------------------------------------------------------------
`default_nettype none
package cfsp_pkg;

	localparam logic [31:0] MAGIC_WORD = 32'hCAFEBABE;

	typedef enum logic [4:0] {
		PH_MAGIC, PH_VERSION, PH_PCOUNT, PH_PTAG, PH_POPER, PH_UTF8,
		PH_ACCESS, PH_THIS, PH_SUPER, PH_ICOUNT, PH_IFACE, PH_FCOUNT,
		PH_FIELD, PH_AHDR, PH_ABYTE, PH_END, PH_IDLE, PH_HALT
	} phase_t;

	typedef enum logic [3:0] {
		K_VERSION = 4'd0, K_POOL = 4'd1, K_UTF8 = 4'd2, K_ACCESS = 4'd3,
		K_THIS = 4'd4, K_SUPER = 4'd5, K_IFACE = 4'd6, K_FIELD = 4'd7,
		K_AHDR = 4'd8, K_ABYTE = 4'd9, K_DONE = 4'd10, K_BAD_MAGIC = 4'd11,
		K_BAD_TAG = 4'd12
	} kind_t;

	localparam logic [7:0] TAG_UTF8   = 8'd1;
	localparam logic [7:0] TAG_LONG   = 8'd5;
	localparam logic [7:0] TAG_DOUBLE = 8'd6;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [7:0]  tag;
		logic [15:0] pool_index;
		logic [63:0] value;
	} out_item_t;

	function automatic logic [3:0] operand_len(input logic [7:0] t);
		case (t)
			8'd1, 8'd7, 8'd8, 8'd16: return 4'd2;
			8'd15: return 4'd3;
			8'd3, 8'd4, 8'd9, 8'd10, 8'd11, 8'd12, 8'd18: return 4'd4;
			8'd5, 8'd6: return 4'd8;
			default: return 4'd0;
		endcase
	endfunction

endpackage
`default_nettype wire

[hdl/cfsp_stream_if.sv]
// ----------------------------------------------------------------------------
// cfsp_stream_if
// valid/ready channel carrying one payload of type T
// ----------------------------------------------------------------------------
`default_nettype none
interface cfsp_stream_if #(parameter type T = logic) (input wire logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/cfsp_core.sv]
// ----------------------------------------------------------------------------
// cfsp_core
// parse state and token generation for one byte per step
// ----------------------------------------------------------------------------
`default_nettype none
module cfsp_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  cfsp_pkg::in_item_t    item,
	output cfsp_pkg::out_item_t   token,
	output logic                  token_valid,
	output logic                  error_q
);
	import cfsp_pkg::*;

	phase_t      phase_q, phase_d;
	logic [3:0]  count_q, count_d;
	logic [63:0] asm_q, asm_d;
	logic [7:0]  tag_q, tag_d;
	logic [15:0] slot_q, slot_d;
	logic [15:0] items_q, items_d;
	logic [31:0] pay_q, pay_d;
	logic [15:0] attr_q, attr_d;
	logic        err_d;

	phase_t      ph;
	logic [3:0]  cnt, cnt1, need, oplen;
	logic [63:0] asmv, word;
	logic [7:0]  tg, b;
	logic [15:0] slot, items, attr, attr_m1, items_m1, slot_p1;
	logic [31:0] pay, pay_m1;
	logic [16:0] nxt;
	logic        done;

	always_comb begin
		b = item.data_byte;
		ph = phase_q; cnt = count_q; asmv = asm_q; tg = tag_q; slot = slot_q;
		items = items_q; pay = pay_q; attr = attr_q; err_d = error_q;
		if (item.first) begin
			ph = PH_MAGIC; cnt = '0; asmv = '0; tg = '0; slot = 16'd1;
			items = '0; pay = '0; attr = '0; err_d = 1'b0;
		end
		phase_d = ph; count_d = cnt; asm_d = asmv; tag_d = tg; slot_d = slot;
		items_d = items; pay_d = pay; attr_d = attr;
		token = '0; token_valid = 1'b0;

		word = {asmv[55:0], b};
		cnt1 = cnt + 4'd1;
		unique case (ph)
			PH_MAGIC, PH_VERSION: need = 4'd4;
			PH_FIELD: need = 4'd8;
			PH_AHDR: need = 4'd6;
			PH_POPER: need = operand_len(tg);
			default: need = 4'd2;
		endcase
		done = (cnt1 >= need);
		oplen = operand_len(b);
		nxt = {1'b0, slot} + ((tg == TAG_LONG || tg == TAG_DOUBLE) ? 17'd2 : 17'd1);
		attr_m1 = attr - 16'd1;
		items_m1 = items - 16'd1;
		slot_p1 = slot + 16'd1;
		pay_m1 = pay - 32'd1;

		if (ph != PH_PTAG && ph != PH_UTF8 && ph != PH_ABYTE && ph != PH_END &&
		    ph != PH_IDLE && ph != PH_HALT) begin
			if (done) begin
				asm_d = '0; count_d = '0;
			end else begin
				asm_d = word; count_d = cnt1;
			end
		end

		unique case (ph)
			PH_MAGIC: if (done) begin
				if (word[31:0] != MAGIC_WORD) begin
					err_d = 1'b1; phase_d = PH_HALT; token_valid = 1'b1;
					token.kind = K_BAD_MAGIC; token.value = {32'd0, word[31:0]};
				end else phase_d = PH_VERSION;
			end
			PH_VERSION: if (done) begin
				phase_d = PH_PCOUNT; token_valid = 1'b1;
				token.kind = K_VERSION; token.value = {32'd0, word[31:0]};
			end
			PH_PCOUNT: if (done) begin
				items_d = word[15:0]; slot_d = 16'd1;
				phase_d = (word[15:0] <= 16'd1) ? PH_ACCESS : PH_PTAG;
			end
			PH_PTAG: begin
				tag_d = b;
				if (oplen == 4'd0) begin
					err_d = 1'b1; phase_d = PH_HALT; token_valid = 1'b1;
					token.kind = K_BAD_TAG; token.tag = b; token.pool_index = slot;
				end else phase_d = PH_POPER;
			end
			PH_POPER: if (done) begin
				token_valid = 1'b1; token.kind = K_POOL; token.tag = tg;
				token.pool_index = slot; token.value = word;
				if (tg == TAG_UTF8 && word != 64'd0) begin
					pay_d = {16'd0, word[15:0]}; phase_d = PH_UTF8;
				end else begin
					phase_d = (nxt >= {1'b0, items}) ? PH_ACCESS : PH_PTAG;
					slot_d = nxt[15:0];
				end
			end
			PH_UTF8: begin
				token_valid = 1'b1; token.kind = K_UTF8; token.pool_index = slot;
				token.value = {56'd0, b}; pay_d = pay_m1;
				if (pay_m1 == 32'd0) begin
					phase_d = (nxt >= {1'b0, items}) ? PH_ACCESS : PH_PTAG;
					slot_d = nxt[15:0];
				end
			end
			PH_ACCESS, PH_THIS, PH_SUPER: if (done) begin
				token_valid = 1'b1; token.value = {48'd0, word[15:0]};
				if (ph == PH_ACCESS) begin
					token.kind = K_ACCESS; phase_d = PH_THIS;
				end else if (ph == PH_THIS) begin
					token.kind = K_THIS; phase_d = PH_SUPER;
				end else begin
					token.kind = K_SUPER; phase_d = PH_ICOUNT;
				end
			end
			PH_ICOUNT: if (done) begin
				items_d = word[15:0]; slot_d = '0;
				phase_d = (word[15:0] != 16'd0) ? PH_IFACE : PH_FCOUNT;
			end
			PH_IFACE: if (done) begin
				token_valid = 1'b1; token.kind = K_IFACE; token.pool_index = slot;
				token.value = {48'd0, word[15:0]};
				slot_d = slot_p1; items_d = items_m1;
				if (items_m1 == 16'd0) phase_d = PH_FCOUNT;
			end
			PH_FCOUNT: if (done) begin
				items_d = word[15:0]; slot_d = '0;
				phase_d = (word[15:0] != 16'd0) ? PH_FIELD : PH_END;
			end
			PH_FIELD: if (done) begin
				token_valid = 1'b1; token.kind = K_FIELD; token.pool_index = slot;
				token.value = word; attr_d = word[15:0];
				if (word[15:0] == 16'd0) begin
					slot_d = slot_p1; items_d = items_m1;
					phase_d = (items_m1 != 16'd0) ? PH_FIELD : PH_END;
				end else phase_d = PH_AHDR;
			end
			PH_AHDR: if (done) begin
				token_valid = 1'b1; token.kind = K_AHDR; token.pool_index = slot;
				token.value = {16'd0, word[47:0]}; pay_d = word[31:0];
				if (word[31:0] == 32'd0) begin
					attr_d = attr_m1;
					if (attr_m1 == 16'd0) begin
						slot_d = slot_p1; items_d = items_m1;
						phase_d = (items_m1 != 16'd0) ? PH_FIELD : PH_END;
					end else phase_d = PH_AHDR;
				end else phase_d = PH_ABYTE;
			end
			PH_ABYTE: begin
				token_valid = 1'b1; token.kind = K_ABYTE; token.pool_index = slot;
				token.value = {56'd0, b}; pay_d = pay_m1;
				if (pay_m1 == 32'd0) begin
					attr_d = attr_m1;
					if (attr_m1 == 16'd0) begin
						slot_d = slot_p1; items_d = items_m1;
						phase_d = (items_m1 != 16'd0) ? PH_FIELD : PH_END;
					end else phase_d = PH_AHDR;
				end
			end
			PH_END: begin
				phase_d = PH_IDLE; token_valid = 1'b1; token.kind = K_DONE;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC; count_q <= '0; asm_q <= '0; tag_q <= '0;
			slot_q <= 16'd1; items_q <= '0; pay_q <= '0; attr_q <= '0;
			error_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d; count_q <= count_d; asm_q <= asm_d; tag_q <= tag_d;
			slot_q <= slot_d; items_q <= items_d; pay_q <= pay_d; attr_q <= attr_d;
			error_q <= err_d;
		end
	end
endmodule
`default_nettype wire

[hdl/class_file_stream_parser.sv]
// ----------------------------------------------------------------------------
// class_file_stream_parser
// byte-stream class file parser emitting one token per byte at most
// ----------------------------------------------------------------------------
// path: a byte is held in the input register, and its token in the output register
// throughput: one byte per cycle unless the output stalls; input register and
// output register each hold one item and move whenever the next stage is free
// reset: arst_n empties both registers and returns the parser to expect magic
`default_nettype none
module class_file_stream_parser (
	input wire logic clk,
	input wire logic arst_n,
	cfsp_stream_if.sink   in_ch,
	cfsp_stream_if.source out_ch
);
	import cfsp_pkg::*;

	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t tok_s2, tok;
	logic      valid_s2, tok_valid, error_q;
	logic      adv_s1;

	assign adv_s1 = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (in_ch.ready) valid_s1 <= in_ch.valid;
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) item_s1 <= in_ch.data;
	end

	cfsp_core u_core (
		.clk(clk), .arst_n(arst_n), .step(adv_s1), .item(item_s1),
		.token(tok), .token_valid(tok_valid), .error_q(error_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else if (!valid_s2 || out_ch.ready) valid_s2 <= adv_s1 && tok_valid;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && tok_valid && (!valid_s2 || out_ch.ready)) tok_s2 <= tok;
	end

	assign out_ch.valid = valid_s2;
	assign out_ch.data  = tok_s2;

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ch.ready |=> valid_s2 && $stable(tok_s2))
		else $error("token dropped under stall");
	a_err_token: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && tok_valid && (tok.kind == K_BAD_MAGIC || tok.kind == K_BAD_TAG)
		|=> error_q)
		else $error("error not latched");
	a_err_silent: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && error_q && !item_s1.first |-> !tok_valid)
		else $error("token after error");
endmodule
`default_nettype wire

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// checks the class file stream parser against a behavioral token predictor,
// driving whole class files, broken files and noise under random stalls
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import cfsp_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors = 0;
	int   src_idle = 0;
	int   snk_idle = 0;

	cfsp_stream_if #(in_item_t)  in_ch (clk);
	cfsp_stream_if #(out_item_t) out_ch (clk);

	class_file_stream_parser dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("testbench failed");
		$finish;
	end

	// predictor state
	phase_t      ph;
	logic [3:0]  nbytes;
	logic [63:0] acc;
	logic [7:0]  cur_tag;
	logic [15:0] slot;
	logic [15:0] left;
	logic [31:0] pay_left;
	logic [15:0] attr_left;
	out_item_t   token_q[$];

	function automatic logic [3:0] tag_len(input logic [7:0] t);
		case (t)
			8'd1, 8'd7, 8'd8, 8'd16: return 4'd2;
			8'd15: return 4'd3;
			8'd3, 8'd4, 8'd9, 8'd10, 8'd11, 8'd12, 8'd18: return 4'd4;
			8'd5, 8'd6: return 4'd8;
			default: return 4'd0;
		endcase
	endfunction

	task automatic parser_clear();
		ph = PH_MAGIC; nbytes = '0; acc = '0; cur_tag = '0; slot = 16'd1;
		left = '0; pay_left = '0; attr_left = '0;
	endtask

	function automatic bit collect(input logic [7:0] b, input int n, output logic [63:0] w);
		acc = {acc[55:0], b};
		nbytes = nbytes + 4'd1;
		if (nbytes >= n) begin
			w = acc; acc = '0; nbytes = '0;
			return 1;
		end
		return 0;
	endfunction

	task automatic add_token(input kind_t k, input logic [7:0] t, input logic [15:0] i,
			input logic [63:0] v);
		out_item_t o;
		o.kind = k; o.tag = t; o.pool_index = i; o.value = v;
		token_q = {token_q, o};
	endtask

	task automatic pool_next();
		logic [16:0] nx;
		nx = {1'b0, slot} + ((cur_tag == TAG_LONG || cur_tag == TAG_DOUBLE) ? 17'd2 : 17'd1);
		ph = (nx >= {1'b0, left}) ? PH_ACCESS : PH_PTAG;
		slot = nx[15:0];
	endtask

	task automatic field_next();
		slot = slot + 16'd1;
		left = left - 16'd1;
		ph = (left != 16'd0) ? PH_FIELD : PH_END;
	endtask

	task automatic attr_done();
		attr_left = attr_left - 16'd1;
		if (attr_left == 16'd0) field_next();
		else ph = PH_AHDR;
	endtask

	task automatic predict_byte(input logic [7:0] b, input logic f);
		logic [63:0] w;
		if (f) parser_clear();
		case (ph)
			PH_MAGIC: if (collect(b, 4, w)) begin
				if (w[31:0] != MAGIC_WORD) begin
					ph = PH_HALT;
					add_token(K_BAD_MAGIC, 8'd0, 16'd0, {32'd0, w[31:0]});
				end else ph = PH_VERSION;
			end
			PH_VERSION: if (collect(b, 4, w)) begin
				ph = PH_PCOUNT;
				add_token(K_VERSION, 8'd0, 16'd0, {32'd0, w[31:0]});
			end
			PH_PCOUNT: if (collect(b, 2, w)) begin
				left = w[15:0]; slot = 16'd1;
				ph = (left <= 16'd1) ? PH_ACCESS : PH_PTAG;
			end
			PH_PTAG: begin
				cur_tag = b;
				if (tag_len(b) == 4'd0) begin
					ph = PH_HALT;
					add_token(K_BAD_TAG, b, slot, 64'd0);
				end else ph = PH_POPER;
			end
			PH_POPER: if (collect(b, int'(tag_len(cur_tag)), w)) begin
				add_token(K_POOL, cur_tag, slot, w);
				if (cur_tag == TAG_UTF8 && w != 64'd0) begin
					pay_left = {16'd0, w[15:0]};
					ph = PH_UTF8;
				end else pool_next();
			end
			PH_UTF8: begin
				add_token(K_UTF8, 8'd0, slot, {56'd0, b});
				pay_left = pay_left - 32'd1;
				if (pay_left == 32'd0) pool_next();
			end
			PH_ACCESS: if (collect(b, 2, w)) begin
				ph = PH_THIS; add_token(K_ACCESS, 8'd0, 16'd0, {48'd0, w[15:0]});
			end
			PH_THIS: if (collect(b, 2, w)) begin
				ph = PH_SUPER; add_token(K_THIS, 8'd0, 16'd0, {48'd0, w[15:0]});
			end
			PH_SUPER: if (collect(b, 2, w)) begin
				ph = PH_ICOUNT; add_token(K_SUPER, 8'd0, 16'd0, {48'd0, w[15:0]});
			end
			PH_ICOUNT: if (collect(b, 2, w)) begin
				left = w[15:0]; slot = 16'd0;
				ph = (left != 16'd0) ? PH_IFACE : PH_FCOUNT;
			end
			PH_IFACE: if (collect(b, 2, w)) begin
				add_token(K_IFACE, 8'd0, slot, {48'd0, w[15:0]});
				slot = slot + 16'd1; left = left - 16'd1;
				if (left == 16'd0) ph = PH_FCOUNT;
			end
			PH_FCOUNT: if (collect(b, 2, w)) begin
				left = w[15:0]; slot = 16'd0;
				ph = (left != 16'd0) ? PH_FIELD : PH_END;
			end
			PH_FIELD: if (collect(b, 8, w)) begin
				add_token(K_FIELD, 8'd0, slot, w);
				attr_left = w[15:0];
				if (attr_left == 16'd0) field_next();
				else ph = PH_AHDR;
			end
			PH_AHDR: if (collect(b, 6, w)) begin
				add_token(K_AHDR, 8'd0, slot, {16'd0, w[47:0]});
				pay_left = w[31:0];
				if (pay_left == 32'd0) attr_done();
				else ph = PH_ABYTE;
			end
			PH_ABYTE: begin
				add_token(K_ABYTE, 8'd0, slot, {56'd0, b});
				pay_left = pay_left - 32'd1;
				if (pay_left == 32'd0) attr_done();
			end
			PH_END: begin
				ph = PH_IDLE; add_token(K_DONE, 8'd0, 16'd0, 64'd0);
			end
			default: ;
		endcase
	endtask

	// driver
	task automatic send_byte(input logic [7:0] b, input logic f);
		while (src_idle != 0 && $urandom_range(99) < src_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= '{data_byte: b, first: f};
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predict_byte(b, f);
	endtask

	task automatic send_u2(input logic [15:0] v, input logic f = 1'b0);
		send_byte(v[15:8], f);
		send_byte(v[7:0], 1'b0);
	endtask

	task automatic send_u4(input logic [31:0] v);
		send_u2(v[31:16]);
		send_u2(v[15:0]);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (token_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// checker
	task automatic report(input string what, input out_item_t got, input out_item_t exp);
		errors++;
		$display("mismatch %s: got %h/%h/%h/%h expected %h/%h/%h/%h", what,
			got.kind, got.tag, got.pool_index, got.value,
			exp.kind, exp.tag, exp.pool_index, exp.value);
	endtask

	always @(posedge clk) begin
		out_item_t got, exp;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (token_q.size() == 0) report("unexpected", got, got);
			else begin
				exp = token_q.pop_front();
				if (got.kind != exp.kind) report("kind", got, exp);
				else if (got.tag != exp.tag) report("tag", got, exp);
				else if (got.pool_index != exp.pool_index) report("pool_index", got, exp);
				else if (got.value != exp.value) report("value", got, exp);
			end
		end
		out_ch.ready <= (snk_idle == 0) || ($urandom_range(99) >= snk_idle);
	end

	// class file builders
	task automatic send_header(input logic [31:0] magic, input logic [31:0] ver);
		send_u2(magic[31:16], 1'b1);
		send_u2(magic[15:0]);
		send_u4(ver);
	endtask

	task automatic send_entry(input logic [7:0] t);
		int n, ulen;
		send_byte(t, 1'b0);
		n = int'(tag_len(t));
		if (t == TAG_UTF8) begin
			ulen = ($urandom_range(5) == 0) ? 0 : int'($urandom_range(6));
			send_u2(16'(ulen));
			repeat (ulen) send_byte(8'($urandom), 1'b0);
		end else repeat (n) send_byte(8'($urandom), 1'b0);
	endtask

	task automatic send_class(input int npool, input int nif, input int nfld);
		logic [7:0] tags[11] = '{1, 3, 4, 5, 6, 7, 8, 9, 10, 15, 18};
		int s, na, alen;
		send_header(MAGIC_WORD, $urandom);
		send_u2(16'(npool));
		s = 1;
		while (s < npool) begin
			logic [7:0] t;
			t = tags[$urandom_range(10)];
			send_entry(t);
			s += (t == TAG_LONG || t == TAG_DOUBLE) ? 2 : 1;
		end
		send_u2(16'($urandom)); send_u2(16'($urandom)); send_u2(16'($urandom));
		send_u2(16'(nif));
		repeat (nif) send_u2(16'($urandom));
		send_u2(16'(nfld));
		repeat (nfld) begin
			na = int'($urandom_range(2));
			send_u4($urandom); send_u2(16'($urandom)); send_u2(16'(na));
			repeat (na) begin
				alen = int'($urandom_range(4));
				send_u2(16'($urandom)); send_u4(32'(alen));
				repeat (alen) send_byte(8'($urandom), 1'b0);
			end
		end
		send_byte(8'($urandom), 1'b0);
		if ($urandom_range(1)) send_byte(8'($urandom), 1'b0);
	endtask

	// tests
	task automatic test_directed();
		send_byte(8'hCA, 1'b0); send_byte(8'hFE, 1'b0);
		send_byte(8'hBA, 1'b0); send_byte(8'hBE, 1'b0);
		send_u4(32'hFFFF_0000);
		send_u2(16'd0);
		send_u2(16'hFFFF); send_u2(16'h0000); send_u2(16'hFFFF);
		send_u2(16'd0); send_u2(16'd0);
		send_byte(8'h00, 1'b0);
		send_header(32'hCAFEBABF, 32'd0);
		send_byte(8'hFF, 1'b0);
		send_header(MAGIC_WORD, 32'h0000FFFF);
		send_u2(16'd3);
		send_entry(TAG_LONG);
		send_entry(TAG_UTF8);
		send_header(MAGIC_WORD, 32'd0);
		send_u2(16'd5);
		send_byte(8'd2, 1'b0);
		send_byte(8'd0, 1'b0);
	endtask

	task automatic test_files(input int nbytes_goal);
		int sent;
		sent = 0;
		while (sent < nbytes_goal) begin
			int r;
			r = int'($urandom_range(9));
			if (r == 0) repeat (6) begin
				send_byte(8'($urandom), $urandom_range(7) == 0); sent++;
			end
			else if (r == 1) begin
				send_header(MAGIC_WORD, $urandom); send_u2(16'd3);
				send_byte($urandom_range(1) ? 8'd0 : 8'($urandom), 1'b0); sent += 11;
			end else begin
				send_class(int'($urandom_range(4)), int'($urandom_range(2)),
					int'($urandom_range(3)));
				sent += 60;
			end
		end
	endtask

	task automatic test_pause();
		send_class(3, 1, 1);
		wait_drained();
		send_class(2, 0, 0);
	endtask

	initial begin
		parser_clear();
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		src_idle = 20; snk_idle = 74;
		test_files(550);
		src_idle = 74; snk_idle = 20;
		test_files(550);
		test_pause();
		src_idle = 0; snk_idle = 0;
		test_files(550);
		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0 && token_q.size() == 0) $display("testbench passed");
		else $display("testbench failed");
		$finish;
	end
endmodule
`default_nettype wire

[filelist.f]
hdl/cfsp_pkg.sv
hdl/cfsp_stream_if.sv
hdl/cfsp_core.sv
hdl/class_file_stream_parser.sv
sim/testbench.sv
